// ----- src/bpc_pkg.sv -----
`timescale 1ns / 1ps

package bpc_pkg;

   // Width of stored times and of time differences (differences wrap modulo 2^TIME_BITS)
   localparam int TIME_BITS = 32;

   // Fixed field widths
   localparam int TIME_NOW_W = 32;
   localparam int CFG_W      = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [CFG_W-1:0]     cfg_val_type;

   // Register indexes (byte address = 4 * index)
   localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
   localparam logic [1:0] REG_DOUBLE_GAP = 2'd1;
   localparam logic [1:0] REG_LONG_PRESS = 2'd2;

   // Reset values of the configuration registers
   localparam cfg_val_type DEBOUNCE_RST   = 16'd30;
   localparam cfg_val_type DOUBLE_GAP_RST = 16'd300;
   localparam cfg_val_type LONG_PRESS_RST = 16'd2000;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_SHORT  = 2'd1,
      EV_DOUBLE = 2'd2,
      EV_LONG   = 2'd3
   } event_type;

   typedef struct packed {
      cfg_val_type debounce_time;
      cfg_val_type double_gap_time;
      cfg_val_type long_press_time;
   } cfg_type;

   typedef struct packed {
      logic     last_raw;
      logic     stable_level;
      time_type change_time;
      time_type press_time;
      time_type release_time;
      logic     long_done;
      logic     short_pending;
   } state_type;

endpackage

// ----- src/bpc_csr.sv -----
`timescale 1ns / 1ps

module bpc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [bpc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [bpc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [bpc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output bpc_pkg::cfg_type                 cfg
);

   bpc_pkg::cfg_type    cfg_ff;
   bpc_pkg::cfg_type    cfg_in;
   logic                wr_en;
   logic [1:0]          reg_idx;
   bpc_pkg::cfg_val_type wr_val;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];
   assign wr_val     = csr_pwdata[bpc_pkg::CFG_W-1:0];

   // Register write decode; the unused index drops the write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            bpc_pkg::REG_DEBOUNCE:   cfg_in.debounce_time   = wr_val;
            bpc_pkg::REG_DOUBLE_GAP: cfg_in.double_gap_time = wr_val;
            bpc_pkg::REG_LONG_PRESS: cfg_in.long_press_time = wr_val;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time   <= bpc_pkg::DEBOUNCE_RST;
         cfg_ff.double_gap_time <= bpc_pkg::DOUBLE_GAP_RST;
         cfg_ff.long_press_time <= bpc_pkg::LONG_PRESS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      unique case (reg_idx)
         bpc_pkg::REG_DEBOUNCE:
            csr_prdata = bpc_pkg::CSR_DATA_W'(cfg_ff.debounce_time);
         bpc_pkg::REG_DOUBLE_GAP:
            csr_prdata = bpc_pkg::CSR_DATA_W'(cfg_ff.double_gap_time);
         bpc_pkg::REG_LONG_PRESS:
            csr_prdata = bpc_pkg::CSR_DATA_W'(cfg_ff.long_press_time);
         default:
            csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ----- src/bpc_step.sv -----
`timescale 1ns / 1ps

module bpc_step (
   input  bpc_pkg::state_type  st,
   input  bpc_pkg::cfg_type    cfg,
   input  logic                level,
   input  bpc_pkg::time_type   now,
   output bpc_pkg::state_type  st_next,
   output bpc_pkg::event_type  ev
);

   bpc_pkg::time_type chg_time;
   bpc_pkg::time_type press_t;
   bpc_pkg::time_type rel_t;
   logic              stable_n;
   logic              long_n;
   logic              pend_n;
   logic              settled;
   logic              long_hit;
   logic              gap_over;

   // Raw change restarts the debounce window
   assign chg_time = (level != st.last_raw) ? now : st.change_time;
   assign settled  = (level != st.stable_level) &&
                     ((now - chg_time) >= bpc_pkg::time_type'(cfg.debounce_time));

   // Stable edge updates
   assign stable_n = settled ? level : st.stable_level;
   assign press_t  = (settled && level)  ? now : st.press_time;
   assign rel_t    = (settled && !level) ? now : st.release_time;

   // Long press and short confirm, against the updated times
   assign long_n   = (settled && level) ? 1'b0 : st.long_done;
   assign long_hit = stable_n && !long_n &&
                     ((now - press_t) >= bpc_pkg::time_type'(cfg.long_press_time));
   assign gap_over = (now - rel_t) > bpc_pkg::time_type'(cfg.double_gap_time);

   // Event priority: short confirm wins over long press, which wins over the release edge
   always_comb begin
      ev     = bpc_pkg::EV_NONE;
      pend_n = st.short_pending;
      // gap test on the release edge never passes (elapsed is zero)
      if (settled && !level && !st.long_done) begin
         if (st.short_pending) begin
            pend_n = 1'b0;
            ev     = bpc_pkg::EV_DOUBLE;
         end else begin
            pend_n = 1'b1;
         end
      end
      if (long_hit) begin
         pend_n = 1'b0;
         ev     = bpc_pkg::EV_LONG;
      end
      if (pend_n && !stable_n && gap_over) begin
         pend_n = 1'b0;
         ev     = bpc_pkg::EV_SHORT;
      end
   end

   always_comb begin
      st_next.last_raw      = level;
      st_next.stable_level  = stable_n;
      st_next.change_time   = chg_time;
      st_next.press_time    = press_t;
      st_next.release_time  = rel_t;
      st_next.long_done     = long_n | long_hit;
      st_next.short_pending = pend_n;
   end

endmodule

// ----- src/button_press_classifier.sv -----
`timescale 1ns / 1ps
// A request accepted into the input register is processed into the result register and shown on rsp_.
// Throughput: one request per cycle while rsp_ready takes each result; the input register refills while a result waits.
// The whole step is one pass of three wrapping subtract-compares between the input
// register and the result register.
// Reset (synchronous, active high) clears the button state and loads the default timings.

module button_press_classifier (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_level,
   input  logic [bpc_pkg::TIME_NOW_W-1:0]      req_time_now,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_event_res,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bpc_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [bpc_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [bpc_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   bpc_pkg::cfg_type    cfg;
   bpc_pkg::state_type  st_ff;
   bpc_pkg::state_type  st_in;
   bpc_pkg::event_type  ev;
   bpc_pkg::event_type  ev_ff;
   logic                in_valid_ff;
   logic                level_ff;
   bpc_pkg::time_type   now_ff;
   logic                out_valid_ff;
   logic                fire;

   bpc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bpc_step u_step (
      .st      (st_ff),
      .cfg     (cfg),
      .level   (level_ff),
      .now     (now_ff),
      .st_next (st_in),
      .ev      (ev)
   );

   // Process the held request when the result register is free or draining
   assign fire      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end
      end
      if (req_valid && req_ready) begin
         level_ff <= req_level;
         now_ff   <= bpc_pkg::time_type'(req_time_now);
      end
   end

   // Button state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            st_ff        <= st_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (fire) begin
         ev_ff <= ev;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_event_res = ev_ff;

   // A long press leaves the press marked done and nothing pending
   assert property (@(posedge clock) disable iff (reset)
      fire && (ev == bpc_pkg::EV_LONG) |=> st_ff.long_done && !st_ff.short_pending)
      else $error("long press did not latch long_done");

   // Short and double events only come out with the button released
   assert property (@(posedge clock) disable iff (reset)
      fire && ((ev == bpc_pkg::EV_SHORT) || (ev == bpc_pkg::EV_DOUBLE))
      |=> !st_ff.stable_level && !st_ff.short_pending)
      else $error("short/double event with button held or still pending");

   // A pending short press never coexists with a held stable press whose long press is done
   assert property (@(posedge clock) disable iff (reset)
      st_ff.short_pending |-> !st_ff.stable_level || st_ff.long_done == 1'b0)
      else $error("pending short press while long press done and held");

   // A processed request always yields a result on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("processed request lost its result");

endmodule
